// ===== design/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg - shared types and constants for the escape-time pipeline
// Fixed-point formats, register indexes, reset values, saturation helpers.
// ----------------------------------------------------------------------------
package mbe_pkg;

	// Field widths
	localparam int IDX_W  = 12;   // pixel column / row index
	localparam int Q_W    = 32;   // Q4.28 value
	localparam int STEP_W = 31;   // unsigned Q3.28 step
	localparam int OUT_W  = 7;    // escape count field
	localparam int FRAC_W = 28;   // fraction bits

	// Wide intermediate widths
	localparam int SQ_W   = 35;   // floor(z*z / 2^28), nonnegative
	localparam int XY_W   = 37;   // floor(zx*zy / 2^27), signed
	localparam int UPD_W  = 38;   // next-z sum before saturation
	localparam int PROD_W = STEP_W + IDX_W;  // step * index
	localparam int C_W    = PROD_W + 2;      // origin +/- step*index

	// Register indexes on the configuration channel
	typedef enum logic [1:0] {
		CFG_ORIGIN_REAL = 2'd0,
		CFG_ORIGIN_IMAG = 2'd1,
		CFG_STEP_REAL   = 2'd2,
		CFG_STEP_IMAG   = 2'd3
	} cfg_idx_t;

	// Register reset values
	localparam logic signed [Q_W-1:0] ORIGIN_REAL_RST = 32'shE000_0000;  // -2.0
	localparam logic signed [Q_W-1:0] ORIGIN_IMAG_RST = 32'sh1000_0000;  //  1.0
	localparam logic [STEP_W-1:0]     STEP_REAL_RST   = 31'd786432;
	localparam logic [STEP_W-1:0]     STEP_IMAG_RST   = 31'd1048576;

	// Q4.28 limits and the |z|^2 escape bound (4.0)
	localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic [SQ_W:0]         ESC_LIMIT = (SQ_W+1)'(4) << FRAC_W;

	// One point in flight: current z, the constant c, and an escaped flag
	typedef struct packed {
		logic                  done;
		logic signed [Q_W-1:0] zx;
		logic signed [Q_W-1:0] zy;
		logic signed [Q_W-1:0] cx;
		logic signed [Q_W-1:0] cy;
	} pt_t;

	// Saturate the next-z sum to Q4.28
	function automatic logic signed [Q_W-1:0] sat_upd(input logic signed [UPD_W-1:0] v);
		logic signed [Q_W-1:0] r;
		if (v > UPD_W'(Q_MAX)) begin
			r = Q_MAX;
		end else if (v < UPD_W'(Q_MIN)) begin
			r = Q_MIN;
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

	// Saturate the pixel coordinate sum to Q4.28
	function automatic logic signed [Q_W-1:0] sat_c(input logic signed [C_W-1:0] v);
		logic signed [Q_W-1:0] r;
		if (v > C_W'(Q_MAX)) begin
			r = Q_MAX;
		end else if (v < C_W'(Q_MIN)) begin
			r = Q_MIN;
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/mbe_pix_if.sv =====
// ----------------------------------------------------------------------------
// mbe_pix_if - pixel coordinate channel
// Valid/ready handshake carrying one pixel's column and row.
// ----------------------------------------------------------------------------
interface mbe_pix_if;
	logic                      valid;
	logic                      ready;
	logic [mbe_pkg::IDX_W-1:0] col_index;
	logic [mbe_pkg::IDX_W-1:0] row_index;

	modport source (output valid, output col_index, output row_index, input ready);
	modport sink   (input valid, input col_index, input row_index, output ready);
endinterface

// ===== design/mbe_cnt_if.sv =====
// ----------------------------------------------------------------------------
// mbe_cnt_if - escape count channel
// Valid/ready handshake carrying one pixel's escape count.
// ----------------------------------------------------------------------------
interface mbe_cnt_if;
	logic                      valid;
	logic                      ready;
	logic [mbe_pkg::OUT_W-1:0] escape_count;

	modport source (output valid, output escape_count, input ready);
	modport sink   (input valid, input escape_count, output ready);
endinterface

// ===== design/mbe_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mbe_cfg_if - configuration write channel
// Valid/ready handshake carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mbe_cfg_if;
	logic                    valid;
	logic                    ready;
	mbe_pkg::cfg_idx_t       index;
	logic [mbe_pkg::Q_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/mbe_iter.sv =====
// ----------------------------------------------------------------------------
// mbe_iter - one unrolled escape-time iteration
// Stage 1 forms the three products, stage 2 checks escape and updates z.
// ----------------------------------------------------------------------------
module mbe_iter #(
	parameter int CNT_W = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  mbe_pkg::pt_t       in_pt,
	input  logic [CNT_W-1:0]   in_cnt,
	output logic               out_valid,
	output mbe_pkg::pt_t       out_pt,
	output logic [CNT_W-1:0]   out_cnt
);
	import mbe_pkg::*;

	// Stage 1: squares and cross product
	logic signed [2*Q_W-1:0] p_xx, p_yy, p_xy;
	logic                    valid_s1;
	pt_t                     pt_s1;
	logic [CNT_W-1:0]        cnt_s1;
	logic [SQ_W-1:0]         zx2_s1, zy2_s1;
	logic signed [XY_W-1:0]  xy_s1;

	assign p_xx = in_pt.zx * in_pt.zx;
	assign p_yy = in_pt.zy * in_pt.zy;
	assign p_xy = in_pt.zx * in_pt.zy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// floor shifts: squares by 28, cross product by 27 (doubles it)
	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1  <= in_pt;
			cnt_s1 <= in_cnt;
			zx2_s1 <= p_xx[SQ_W+FRAC_W-1:FRAC_W];
			zy2_s1 <= p_yy[SQ_W+FRAC_W-1:FRAC_W];
			xy_s1  <= p_xy[2*Q_W-1:FRAC_W-1];
		end
	end

	// Stage 2: escape check and z update
	logic [SQ_W:0]           mag;
	logic                    escape;
	logic signed [UPD_W-1:0] sum_x, sum_y;
	logic                    valid_s2;
	pt_t                     pt_s2;
	logic [CNT_W-1:0]        cnt_s2;

	assign mag    = (SQ_W+1)'(zx2_s1) + (SQ_W+1)'(zy2_s1);
	assign escape = (mag >= ESC_LIMIT);
	assign sum_x  = signed'(UPD_W'(zx2_s1)) - signed'(UPD_W'(zy2_s1)) + UPD_W'(pt_s1.cx);
	assign sum_y  = UPD_W'(xy_s1) + UPD_W'(pt_s1.cy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	// escaped points pass through with their count frozen
	always_ff @(posedge clk) begin
		if (en) begin
			if (pt_s1.done || escape) begin
				pt_s2.done <= 1'b1;
				pt_s2.zx   <= pt_s1.zx;
				pt_s2.zy   <= pt_s1.zy;
				pt_s2.cx   <= pt_s1.cx;
				pt_s2.cy   <= pt_s1.cy;
				cnt_s2     <= cnt_s1;
			end else begin
				pt_s2.done <= 1'b0;
				pt_s2.zx   <= sat_upd(sum_x);
				pt_s2.zy   <= sat_upd(sum_y);
				pt_s2.cx   <= pt_s1.cx;
				pt_s2.cy   <= pt_s1.cy;
				cnt_s2     <= CNT_W'(cnt_s1 + 1'b1);
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_pt    = pt_s2;
	assign out_cnt   = cnt_s2;

	// a point that has not escaped gains exactly one count per iteration
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s1 && !pt_s1.done && !escape |=> cnt_s2 == CNT_W'($past(cnt_s1) + 1'b1))
		else $error("iteration count did not advance");
	// an escaped point keeps its count
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s1 && pt_s1.done |=> pt_s2.done && cnt_s2 == $past(cnt_s1))
		else $error("escaped point changed its count");
	// a stall freezes both stages
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s1) && $stable(valid_s2))
		else $error("iteration stage moved during stall");

endmodule

// ===== design/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time - Mandelbrot escape count per pixel
// Maps a pixel to c in Q4.28 and runs an unrolled z = z^2 + c pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  : sink channel, one transaction per pixel (col_index, row_index).
//   result : source channel, one escape_count per pixel, in input order.
//   cfg    : register writes (origin_real, origin_imag, step_real,
//            step_imag); always ready, write only while no pixel is in flight.
// Throughput: one pixel per cycle unless a result waits on result.ready. Every iteration is its own hardware,
//   a multiply stage and an update stage, so pixels never share a unit.
// Stages: two form c, then two per iteration, from pixel transaction to
//   result valid.
// Reset: clears all pipeline valid bits and loads the default view
//   (left edge -2.0, top edge 1.0).
// Stall: while a result waits and result.ready is low, the whole pipeline
//   holds and pixel.ready drops; nothing is lost or repeated.
// Column and row indexes beyond IMAGE_DIM-1 are clamped to IMAGE_DIM-1.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time #(
	parameter int MAX_ITER  = 100,
	parameter int IMAGE_DIM = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	mbe_pix_if.sink   pixel,
	mbe_cnt_if.source result,
	mbe_cfg_if.sink   cfg
);
	import mbe_pkg::*;

	localparam int         CNT_W    = $clog2(MAX_ITER + 1);
	localparam logic [16:0] DIM_LAST = 17'(IMAGE_DIM - 1);

	// Configuration registers
	logic signed [Q_W-1:0] origin_real_q, origin_imag_q;
	logic [STEP_W-1:0]     step_real_q, step_imag_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_real_q <= ORIGIN_REAL_RST;
			origin_imag_q <= ORIGIN_IMAG_RST;
			step_real_q   <= STEP_REAL_RST;
			step_imag_q   <= STEP_IMAG_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ORIGIN_REAL: origin_real_q <= cfg.data;
				CFG_ORIGIN_IMAG: origin_imag_q <= cfg.data;
				CFG_STEP_REAL:   step_real_q   <= cfg.data[STEP_W-1:0];
				CFG_STEP_IMAG:   step_imag_q   <= cfg.data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline advance: the whole chain moves unless a result is held
	logic last_valid;
	logic en;

	assign en          = !last_valid || result.ready;
	assign pixel.ready = en;

	// Stage 1: clamp indexes, scale by the steps
	logic [IDX_W-1:0]  col_c, row_c;
	logic              valid_s1;
	logic [PROD_W-1:0] prod_re_s1, prod_im_s1;

	assign col_c = ({5'b0, pixel.col_index} > DIM_LAST) ? DIM_LAST[IDX_W-1:0] : pixel.col_index;
	assign row_c = ({5'b0, pixel.row_index} > DIM_LAST) ? DIM_LAST[IDX_W-1:0] : pixel.row_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_re_s1 <= PROD_W'(step_real_q) * PROD_W'(col_c);
			prod_im_s1 <= PROD_W'(step_imag_q) * PROD_W'(row_c);
		end
	end

	// Stage 2: add origins, saturate, seed z = c
	logic signed [C_W-1:0] sum_re, sum_im;
	logic                  valid_s2;
	pt_t                   pt_s2;

	assign sum_re = C_W'(origin_real_q) + signed'(C_W'(prod_re_s1));
	assign sum_im = C_W'(origin_imag_q) - signed'(C_W'(prod_im_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s2.done <= 1'b0;
			pt_s2.cx   <= sat_c(sum_re);
			pt_s2.cy   <= sat_c(sum_im);
			pt_s2.zx   <= sat_c(sum_re);
			pt_s2.zy   <= sat_c(sum_im);
		end
	end

	// Iteration chain: link 0 is the seed, link k is after k iterations
	logic             chain_valid [MAX_ITER+1];
	pt_t              chain_pt    [MAX_ITER+1];
	logic [CNT_W-1:0] chain_cnt   [MAX_ITER+1];

	assign chain_valid[0] = valid_s2;
	assign chain_pt[0]    = pt_s2;
	assign chain_cnt[0]   = '0;

	for (genvar k = 0; k < MAX_ITER; k++) begin : g_iter
		mbe_iter #(
			.CNT_W (CNT_W)
		) u_iter (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_valid[k]),
			.in_pt     (chain_pt[k]),
			.in_cnt    (chain_cnt[k]),
			.out_valid (chain_valid[k+1]),
			.out_pt    (chain_pt[k+1]),
			.out_cnt   (chain_cnt[k+1])
		);
	end

	// Output: the last iteration register is the result register
	logic [CNT_W+OUT_W-1:0] cnt_ext;

	assign last_valid          = chain_valid[MAX_ITER];
	assign cnt_ext             = {{OUT_W{1'b0}}, chain_cnt[MAX_ITER]};
	assign result.valid        = last_valid;
	assign result.escape_count = cnt_ext[OUT_W-1:0];

	// an accepted pixel enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.ready |=> valid_s1)
		else $error("accepted pixel did not enter the pipeline");
	// a count below the limit means the point escaped
	a_escaped: assert property (@(posedge clk) disable iff (!arst_n)
		last_valid && chain_cnt[MAX_ITER] != CNT_W'(MAX_ITER) |-> chain_pt[MAX_ITER].done)
		else $error("short count on a point that did not escape");
	// the count never exceeds the iteration limit
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		last_valid |-> chain_cnt[MAX_ITER] <= CNT_W'(MAX_ITER))
		else $error("escape count above the iteration limit");

endmodule

// ===== verif/tb_mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time - testbench for the escape-time pipeline
// Drives pixel transactions through several views, predicts each escape count
// with a Q4.28 model kept in a scoreboard class, and checks results in order.
// Both channels idle at random, with one stretch at full rate.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time;
	import mbe_pkg::*;

	localparam int MAX_ITER     = 100;
	localparam int IMAGE_DIM    = 4096;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 2 * MAX_ITER + 50;
	localparam int PHASES       = 9;
	localparam int PHASE_PIXELS = 200;

	logic    clk;
	logic    arst_n;
	int      src_idle_pct;
	int      snk_idle_pct;
	longint  cycle_count = 0;

	mbe_pix_if pix();
	mbe_cnt_if res();
	mbe_cfg_if cfgc();

	mandelbrot_escape_time #(
		.MAX_ITER (MAX_ITER),
		.IMAGE_DIM(IMAGE_DIM)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pixel (pix),
		.result(res),
		.cfg   (cfgc)
	);

	// Escape-count predictor and in-order store of pending counts
	class escape_scoreboard;
		longint            orig_re;
		longint            orig_im;
		longint            step_re;
		longint            step_im;
		logic [OUT_W-1:0]  expected_counts[$];
		int unsigned       errors;

		function new();
			orig_re = longint'(ORIGIN_REAL_RST);
			orig_im = longint'(ORIGIN_IMAG_RST);
			step_re = longint'(STEP_REAL_RST);
			step_im = longint'(STEP_IMAG_RST);
			errors  = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [Q_W-1:0] value);
			case (idx)
				CFG_ORIGIN_REAL: orig_re = longint'(signed'(value));
				CFG_ORIGIN_IMAG: orig_im = longint'(signed'(value));
				CFG_STEP_REAL:   step_re = longint'(value[STEP_W-1:0]);
				CFG_STEP_IMAG:   step_im = longint'(value[STEP_W-1:0]);
				default: ;
			endcase
		endfunction

		function longint sat_q(longint v);
			if (v > longint'(Q_MAX)) begin
				return longint'(Q_MAX);
			end
			if (v < longint'(Q_MIN)) begin
				return longint'(Q_MIN);
			end
			return v;
		endfunction

		// c from the pixel, then z = z^2 + c until |z|^2 >= 4 or the limit
		function logic [OUT_W-1:0] escape_count_of(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
			longint      ci, ri, cx, cy, zx, zy, zx2, zy2, nzx;
			longint      bound;
			int unsigned n;
			bound = longint'(4) << FRAC_W;
			ci = longint'(col);
			ri = longint'(row);
			if (ci >= IMAGE_DIM) begin
				ci = IMAGE_DIM - 1;
			end
			if (ri >= IMAGE_DIM) begin
				ri = IMAGE_DIM - 1;
			end
			cx  = sat_q(orig_re + step_re * ci);
			cy  = sat_q(orig_im - step_im * ri);
			zx  = cx;
			zy  = cy;
			zx2 = (zx * zx) >>> FRAC_W;
			zy2 = (zy * zy) >>> FRAC_W;
			n   = 0;
			while (n < MAX_ITER && (zx2 + zy2) < bound) begin
				// 2*zx*zy: shift by one bit less instead of doubling
				nzx = sat_q(zx2 - zy2 + cx);
				zy  = sat_q(((zx * zy) >>> (FRAC_W - 1)) + cy);
				zx  = nzx;
				zx2 = (zx * zx) >>> FRAC_W;
				zy2 = (zy * zy) >>> FRAC_W;
				n++;
			end
			return OUT_W'(n);
		endfunction

		function void note_pixel(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
			expected_counts.push_back(escape_count_of(col, row));
		endfunction

		function void check_count(logic [OUT_W-1:0] got);
			logic [OUT_W-1:0] want;
			if (expected_counts.size() == 0) begin
				$error("escape_count: unexpected result %0d, none pending", got);
				errors++;
			end else begin
				want = expected_counts.pop_front();
				if (got !== want) begin
					$error("escape_count mismatch: expected %0d, actual %0d", want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_counts.size();
		endfunction
	endclass

	escape_scoreboard sb;

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Result side: check each transaction, then pick next ready
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			sb.check_count(res.escape_count);
		end
		res.ready <= arst_n && ($urandom_range(0, 99) >= snk_idle_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// One pixel transaction, with random idle cycles ahead of it
	task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid     <= 1'b1;
		pix.col_index <= col;
		pix.row_index <= row;
		@(posedge clk);
		while (!pix.ready) begin
			@(posedge clk);
		end
		sb.note_pixel(col, row);
	endtask

	// Stop sending and wait until every pending count has come back
	task automatic wait_drained();
		pix.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (sb.pending() != 0);
	endtask

	// Write all four view registers back to back
	task automatic load_view(input logic [Q_W-1:0] ore, input logic [Q_W-1:0] oim,
	                         input logic [Q_W-1:0] sre, input logic [Q_W-1:0] sim);
		logic [Q_W-1:0] vals[4];
		cfg_idx_t       idx;
		vals = '{ore, oim, sre, sim};
		idx  = CFG_ORIGIN_REAL;
		for (int k = 0; k < 4; k++) begin
			cfgc.valid <= 1'b1;
			cfgc.index <= idx;
			cfgc.data  <= vals[k];
			@(posedge clk);
			while (!cfgc.ready) begin
				@(posedge clk);
			end
			sb.set_reg(idx, vals[k]);
			idx = idx.next();
		end
		cfgc.valid <= 1'b0;
	endtask

	// Random step with a random (ignored) top bit
	function automatic logic [Q_W-1:0] rand_step(input int lo, input int hi);
		return {1'($urandom_range(0, 1)), STEP_W'($urandom_range(lo, hi))};
	endfunction

	initial begin
		logic [Q_W-1:0] ore, oim, sre, sim;
		int             col_span, row_span, mode;

		sb            = new();
		pix.valid     = 1'b0;
		pix.col_index = '0;
		pix.row_index = '0;
		cfgc.valid    = 1'b0;
		cfgc.index    = CFG_ORIGIN_REAL;
		cfgc.data     = '0;
		src_idle_pct  = 30;
		snk_idle_pct  = 51;
		arst_n        = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset view: outside points, saturated corners, points in the set
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd512, 12'd256);
		send_pixel(12'd683, 12'd256);
		send_pixel(12'd440, 12'd256);
		send_pixel(12'd600, 12'd200);
		send_pixel(12'd85, 12'd256);

		// c = 0 everywhere: never escapes
		wait_drained();
		load_view(32'h0, 32'h0, 32'h0, 32'h0);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);

		// Extreme origins and steps; top step bit set and masked
		wait_drained();
		load_view(Q_MIN, Q_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd1);
		send_pixel(12'd2, 12'd0);
		send_pixel(12'd4095, 12'd4095);

		wait_drained();
		load_view(Q_MAX, Q_MIN, 32'h8000_0000, 32'h8000_0000);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);

		// |c|^2 exactly 4 on the first point, immediate escapes near 7.0 after it
		wait_drained();
		load_view(32'hE000_0000, 32'h0, 32'h0010_0000, 32'h0);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd2304, 12'd0);
		send_pixel(12'd2305, 12'd0);
		send_pixel(12'd2310, 12'd7);

		// Random views, mostly pixels inside the interesting region
		for (int ph = 0; ph < PHASES; ph++) begin
			src_idle_pct = (ph < 3) ? 30 : ((ph < 6) ? 51 : 0);
			snk_idle_pct = (ph < 3) ? 51 : ((ph < 6) ? 30 : 0);
			wait_drained();
			mode     = ph % 4;
			col_span = 4095;
			row_span = 4095;
			case (mode)
				0: begin
					ore = 32'hE000_0000 - $urandom_range(0, 1 << 26);
					oim = 32'h1000_0000 + $urandom_range(0, 1 << 26);
					sre = rand_step(1 << 16, 1 << 20);
					sim = rand_step(1 << 16, 1 << 20);
					col_span = 805306368 / int'(sre[STEP_W-1:0]);
					row_span = 536870912 / int'(sim[STEP_W-1:0]);
					if (col_span > 4095) col_span = 4095;
					if (row_span > 4095) row_span = 4095;
				end
				1: begin
					// close in on the boundary near -0.75 + 0.125i
					ore = 32'hF400_0000 + $urandom_range(0, 1 << 24) - (1 << 23);
					oim = 32'h0200_0000 + $urandom_range(0, 1 << 24) - (1 << 23);
					sre = rand_step(1, 1 << 12);
					sim = rand_step(1, 1 << 12);
				end
				2: begin
					ore = $urandom;
					oim = $urandom;
					sre = $urandom;
					sim = $urandom;
				end
				default: begin
					ore = ORIGIN_REAL_RST;
					oim = ORIGIN_IMAG_RST;
					sre = {1'($urandom_range(0, 1)), STEP_REAL_RST};
					sim = {1'($urandom_range(0, 1)), STEP_IMAG_RST};
				end
			endcase
			load_view(ore, oim, sre, sim);
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				if ($urandom_range(0, 99) < 85) begin
					send_pixel(IDX_W'($urandom_range(0, col_span)),
					           IDX_W'($urandom_range(0, row_span)));
				end else begin
					send_pixel(IDX_W'($urandom), IDX_W'($urandom));
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
